>>> rtl/unp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// unp_pkg
// Shared types and character codes for the unsigned number text parser.
// ----------------------------------------------------------------------------
package unp_pkg;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_LOW_F = 8'h66;
    localparam logic [7:0] CHAR_LOW_H = 8'h68;
    localparam logic [7:0] CHAR_LOW_X = 8'h78;
    localparam logic [7:0] CASE_BIT   = 8'h20;
    localparam logic [3:0] HEX_ALPHA_OFFSET = 4'd9;
    localparam logic [1:0] SEEN_MAX   = 2'd3;

    // Parser flags carried from byte to byte
    typedef struct packed {
        logic [1:0] nonblank_seen;
        logic       zero_lead_adjacent;
        logic       prefix_mode;
        logic       decimal_legal;
        logic       hex_legal;
        logic       blank_gap;
        logic       suffix_pending;
    } t_flags;

    localparam t_flags FLAGS_RESET = '{
        nonblank_seen:      2'd0,
        zero_lead_adjacent: 1'b0,
        prefix_mode:        1'b0,
        decimal_legal:      1'b1,
        hex_legal:          1'b1,
        blank_gap:          1'b0,
        suffix_pending:     1'b0
    };

endpackage
`default_nettype wire

>>> rtl/unsigned_number_text_parser_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// unsigned_number_text_parser_core
// Streaming parser of a NUL-terminated decimal or hexadecimal string.
// ----------------------------------------------------------------------------
// Takes one byte per cycle, back to back, while the result is not stalled, and
// gives one result (ok, value) per NUL byte. The NUL passes the input register
// and loads the result register, which drives the output. Each byte passes
// an input register, one multiply-by-ten add and one shift-add in parallel,
// and updates the parser state; a NUL loads the result register and returns
// the state to its reset values. A stalled result holds every request in the
// input register. An empty input register still takes one request while the
// result register waits, so the stall reaches the input at once when a request
// is already waiting and only once that request is loaded otherwise.
module unsigned_number_text_parser_core #(
    parameter int VALUE_WIDTH = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [7:0]             i_character,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic                        o_ok,
    output logic [VALUE_WIDTH-1:0]      o_value
);

    logic                   r_in_valid;
    logic [7:0]             r_char;
    unp_pkg::t_flags        r_flags;
    logic [VALUE_WIDTH-1:0] r_decimal_sum;
    logic [VALUE_WIDTH-1:0] r_hex_sum;
    logic                   r_out_valid;
    logic                   r_ok;
    logic [VALUE_WIDTH-1:0] r_value;

    unp_pkg::t_flags        n_flags;
    logic [VALUE_WIDTH-1:0] n_decimal_sum;
    logic [VALUE_WIDTH-1:0] n_hex_sum;
    logic                   n_ok;
    logic [VALUE_WIDTH-1:0] n_value;

    logic advance;
    logic fire;
    logic is_end;

    unp_step #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_step (
        .i_character   (r_char),
        .i_flags       (r_flags),
        .i_decimal_sum (r_decimal_sum),
        .i_hex_sum     (r_hex_sum),
        .o_flags       (n_flags),
        .o_decimal_sum (n_decimal_sum),
        .o_hex_sum     (n_hex_sum),
        .o_ok          (n_ok),
        .o_value       (n_value)
    );

    assign advance = !(r_out_valid && i_stall);
    assign fire    = r_in_valid && advance;
    assign is_end  = (r_char == unp_pkg::CHAR_NUL);
    assign o_stall = r_in_valid && !advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (i_valid && !o_stall) begin
            r_char <= i_character;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags       <= unp_pkg::FLAGS_RESET;
            r_decimal_sum <= '0;
            r_hex_sum     <= '0;
        end else if (fire) begin
            if (is_end) begin
                r_flags       <= unp_pkg::FLAGS_RESET;
                r_decimal_sum <= '0;
                r_hex_sum     <= '0;
            end else begin
                r_flags       <= n_flags;
                r_decimal_sum <= n_decimal_sum;
                r_hex_sum     <= n_hex_sum;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire && is_end;
        end
        if (fire && is_end) begin
            r_ok    <= n_ok;
            r_value <= n_value;
        end
    end

    assign o_valid = r_out_valid;
    assign o_ok    = r_ok;
    assign o_value = r_value;

endmodule
`default_nettype wire

>>> rtl/unp_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// unp_step
// Next-state logic for one byte: flag update, decimal and hex multiply-add,
// and the final verdict taken from the current state on a NUL.
// ----------------------------------------------------------------------------
module unp_step #(
    parameter int VALUE_WIDTH = 64
) (
    input  wire logic [7:0]             i_character,
    input  wire unp_pkg::t_flags        i_flags,
    input  wire logic [VALUE_WIDTH-1:0] i_decimal_sum,
    input  wire logic [VALUE_WIDTH-1:0] i_hex_sum,
    output unp_pkg::t_flags             o_flags,
    output logic [VALUE_WIDTH-1:0]      o_decimal_sum,
    output logic [VALUE_WIDTH-1:0]      o_hex_sum,
    output logic                        o_ok,
    output logic [VALUE_WIDTH-1:0]      o_value
);

    logic [7:0] low;
    logic       is_digit;
    logic       is_hex_alpha;
    logic [3:0] hex_nibble;
    logic [VALUE_WIDTH-1:0] dec_next;
    logic [VALUE_WIDTH-1:0] hex_next;

    assign low          = i_character | unp_pkg::CASE_BIT;
    assign is_digit     = (i_character >= unp_pkg::CHAR_ZERO) &&
                          (i_character <= unp_pkg::CHAR_NINE);
    assign is_hex_alpha = (low >= unp_pkg::CHAR_LOW_A) && (low <= unp_pkg::CHAR_LOW_F);
    assign hex_nibble   = is_digit ? i_character[3:0]
                                   : low[3:0] + unp_pkg::HEX_ALPHA_OFFSET;

    // times ten as shift-and-add
    assign dec_next = (i_decimal_sum << 3) + (i_decimal_sum << 1)
                    + VALUE_WIDTH'(i_character[3:0]);
    assign hex_next = (i_hex_sum << 4) + VALUE_WIDTH'(hex_nibble);

    always_comb begin
        o_flags       = i_flags;
        o_decimal_sum = i_decimal_sum;
        o_hex_sum     = i_hex_sum;

        if (i_character <= unp_pkg::CHAR_SPACE) begin
            o_flags.zero_lead_adjacent = 1'b0;
            if (i_flags.nonblank_seen != 2'd0) begin
                o_flags.blank_gap = 1'b1;
            end
        end else begin
            if (i_flags.blank_gap || i_flags.suffix_pending) begin
                o_flags.hex_legal = 1'b0;
            end
            o_flags.suffix_pending = 1'b0;

            if (is_digit) begin
                o_decimal_sum = dec_next;
            end else if (i_character != unp_pkg::CHAR_COMMA &&
                         i_character != unp_pkg::CHAR_DOT) begin
                o_flags.decimal_legal = 1'b0;
            end

            priority if (i_flags.zero_lead_adjacent && low == unp_pkg::CHAR_LOW_X) begin
                o_flags.prefix_mode = 1'b1;
            end else if (i_character == unp_pkg::CHAR_LOW_H && !i_flags.prefix_mode) begin
                o_flags.suffix_pending = 1'b1;
            end else if (is_digit || is_hex_alpha) begin
                o_hex_sum = hex_next;
            end else begin
                o_flags.hex_legal = 1'b0;
            end

            o_flags.zero_lead_adjacent = (i_flags.nonblank_seen == 2'd0) &&
                                         (i_character == unp_pkg::CHAR_ZERO);
            if (i_flags.nonblank_seen != unp_pkg::SEEN_MAX) begin
                o_flags.nonblank_seen = i_flags.nonblank_seen + 2'd1;
            end
            o_flags.blank_gap = 1'b0;
        end
    end

    // Verdict on the string so far, used when the byte is a NUL
    always_comb begin
        logic ok;
        logic [VALUE_WIDTH-1:0] val;
        priority if (i_flags.nonblank_seen == 2'd0) begin
            ok  = 1'b0;
            val = '0;
        end else if (i_flags.prefix_mode) begin
            ok  = i_flags.hex_legal && (i_flags.nonblank_seen == unp_pkg::SEEN_MAX);
            val = i_hex_sum;
        end else if (i_flags.suffix_pending) begin
            ok  = i_flags.hex_legal && (i_flags.nonblank_seen >= 2'd2);
            val = i_hex_sum;
        end else begin
            ok  = i_flags.decimal_legal;
            val = i_decimal_sum;
        end
        o_ok    = ok;
        o_value = ok ? val : '0;
    end

endmodule
`default_nettype wire
